FILE: rtl/core/slbc_pkg.sv
// Shared types, constants and segment arithmetic for the status LED blink-code sequencer.
package slbc_pkg;

  localparam int SHORT_W  = 12;
  localparam int FRAME_W  = 16;
  localparam int GAP_W    = 16;
  localparam int REPEAT_W = 4;
  localparam int FLAG_W   = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Tick counter width; segment lengths above its range saturate.
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Width of a raw segment length before saturation (5 * short fits in it).
  localparam int LEN_W = FRAME_W;

  localparam int MAX_SEGS = 6;
  localparam int SEG_W    = 3;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [2:0] FLAG_ON     = 3'd0;
  localparam logic [2:0] FLAG_UPDATE = 3'd1;
  localparam logic [2:0] FLAG_NO_CAN = 3'd2;
  localparam logic [2:0] FLAG_NO_GPS = 3'd3;
  localparam logic [2:0] FLAG_NO_COM = 3'd4;
  localparam logic [2:0] FLAG_POWER  = 3'd5;
  localparam logic [2:0] FLAG_LAST   = 3'd6;

  localparam logic [FLAG_W-1:0] PATTERN_MASK = 7'h3E;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd3;

  localparam logic [SHORT_W-1:0]  SHORT_RST  = 12'd100;
  localparam logic [FRAME_W-1:0]  FRAME_RST  = 16'd1000;
  localparam logic [GAP_W-1:0]    GAP_RST    = 16'd10;
  localparam logic [REPEAT_W-1:0] REPEAT_RST = 4'd2;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_STEADY     = 4'd1,
    PH_UPDATE     = 4'd2,
    PH_CAN        = 4'd3,
    PH_COMM       = 4'd4,
    PH_GPS        = 4'd5,
    PH_POWER_LONG = 4'd6,
    PH_POWER_FAST = 4'd7,
    PH_GAP        = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [SEG_W-1:0]    idx;
    logic [REPEAT_W-1:0] reps;
    logic [CNT_W-1:0]    ticks;
    logic                led;
  } seq_t;

  typedef struct packed {
    logic             found;
    logic [SEG_W-1:0] idx;
  } nz_t;

  typedef struct packed {
    logic             hit;
    phase_t           phase;
    logic [SEG_W-1:0] idx;
    logic             touched;
  } scan_t;

  function automatic logic [CNT_W-1:0] sat_len(logic [LEN_W-1:0] v);
    if (LEN_W > CNT_W && v > LEN_W'(CNT_MAX)) return CNT_MAX;
    return CNT_W'(v);
  endfunction

  function automatic logic [LEN_W-1:0] sub0(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [2:0] flag_bit(phase_t p);
    logic [2:0] r;
    case (p)
      PH_UPDATE: r = FLAG_UPDATE;
      PH_CAN:    r = FLAG_NO_CAN;
      PH_COMM:   r = FLAG_NO_COM;
      PH_GPS:    r = FLAG_NO_GPS;
      default:   r = FLAG_POWER;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] seg_cnt(phase_t p);
    logic [3:0] r;
    case (p)
      PH_COMM: r = 4'd4;
      PH_GPS:  r = 4'd6;
      default: r = 4'd2;
    endcase
    return r;
  endfunction

  // Raw length of segment k of pattern p; the last off period of the CAN, comm and GPS patterns fills its frame.
  function automatic logic [LEN_W-1:0] seg_len(phase_t p, logic [SEG_W-1:0] k,
                                               logic [SHORT_W-1:0] s,
                                               logic [FRAME_W-1:0] f);
    logic [LEN_W-1:0] sl, fl, s2, s3, s5, r;
    sl = LEN_W'(s);
    fl = LEN_W'(f);
    s2 = sl << 1;
    s3 = s2 + sl;
    s5 = (sl << 2) + sl;
    case (p)
      PH_CAN:        r = (k == 3'd1) ? sub0(fl, sl) : sl;
      PH_COMM:       r = (k == 3'd3) ? sub0(fl, s3) : sl;
      PH_GPS:        r = (k == 3'd5) ? sub0(fl, s5) : sl;
      PH_POWER_LONG: r = fl;
      PH_POWER_FAST: r = s2;
      default:       r = sl;
    endcase
    return r;
  endfunction

  // First segment at or after start with a nonzero length.
  function automatic nz_t first_nz(phase_t p, logic [3:0] start,
                                   logic [SHORT_W-1:0] s, logic [FRAME_W-1:0] f);
    nz_t        r;
    logic [3:0] cnt;
    r.found = 1'b0;
    r.idx   = '0;
    cnt     = seg_cnt(p);
    for (int k = MAX_SEGS - 1; k >= 0; k--) begin
      if (4'(k) >= start && 4'(k) < cnt && seg_len(p, SEG_W'(k), s, f) != '0) begin
        r.found = 1'b1;
        r.idx   = SEG_W'(k);
      end
    end
    return r;
  endfunction

  // Finds the first pattern at or after from that plays time. touched tells that a
  // pattern of zero length was passed through, which leaves the LED off.
  function automatic scan_t scan_patterns(logic [3:0] from, logic [FLAG_W-1:0] flags,
                                          logic [REPEAT_W-1:0] rcnt,
                                          logic [SHORT_W-1:0] s, logic [FRAME_W-1:0] f);
    scan_t  r;
    logic   done;
    phase_t pq;
    nz_t    fn;
    r.hit     = 1'b0;
    r.phase   = PH_GAP;
    r.idx     = '0;
    r.touched = 1'b0;
    done      = 1'b0;
    for (int q = 2; q <= 7; q++) begin
      pq = phase_t'(4'(q));
      fn = first_nz(pq, 4'd0, s, f);
      if (!done && 4'(q) >= from && flags[flag_bit(pq)]) begin
        if (rcnt != '0) begin
          if (fn.found) begin
            r.hit   = 1'b1;
            r.phase = pq;
            r.idx   = fn.idx;
            done    = 1'b1;
          end else begin
            r.touched = 1'b1;
          end
        end
        if (pq == PH_UPDATE) done = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/status_led_blink_code_sequencer_top.sv
// Status LED blink-code sequencer: flag store, pass sequencer and output buffer.
// A result beat is registered before it is offered on the m side. Throughput: one input
// beat per cycle while no skid entry waits; the sequencer step is one registered pass of logic.
// An output register plus one skid entry let an input beat be taken while a result waits.
// Reset (rst, synchronous, active high) clears all flags, sets the sequencer to the end of
// a gap so the first tick starts a pass, turns the LED off and restores register defaults.
module status_led_blink_code_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] flag_value, [7:1] zero
  input  logic [4:0]                    s_tuser,   // [1:0] command, [4:2] flag_select
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [0] led_on, [4:1] active_pattern, [7:5] zero
  // Register write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slbc_pkg::CFG_W-1:0]     cfg_data
);
  import slbc_pkg::*;

  // Configuration registers.
  logic [SHORT_W-1:0]  short_ticks;
  logic [FRAME_W-1:0]  frame_ticks;
  logic [GAP_W-1:0]    gap_ticks;
  logic [REPEAT_W-1:0] repeat_count;

  // Sequencer state and flags.
  seq_t               st;
  seq_t               st_r1;
  seq_t               st_next;
  logic [FLAG_W-1:0]  status_flags;
  logic [FLAG_W-1:0]  status_flags_next;

  // Output buffer.
  logic       skid_valid;
  logic [7:0] skid_data;
  logic [7:0] res_data;

  logic       in_fire;
  logic [1:0] in_cmd;
  logic [2:0] in_sel;
  logic       in_val;
  logic       start_pass;

  // Round one temporaries.
  nz_t                 rest_nz;
  nz_t                 wrap_nz;
  scan_t               next_scan;
  scan_t               pass_scan;
  logic [REPEAT_W-1:0] reps_dec;
  logic                loaded_rest;
  logic                led_pre;
  logic [3:0]          rest_start;

  // Neither the input stream nor the register channel takes a beat while reset is held.
  assign cfg_ready = !rst;
  assign s_tready  = !skid_valid && !rst;
  assign in_fire   = s_tvalid && s_tready;
  assign in_cmd    = s_tuser[1:0];
  assign in_sel    = s_tuser[4:2];
  assign in_val    = s_tdata[0];

  // Round one: count the tick down; when a pattern segment ends, move on within the current
  // pattern, wrap for the next repetition, or hand over to the next pattern. Segments of
  // zero length are skipped in the same tick.
  always_comb begin
    st_r1       = st;
    start_pass  = 1'b0;
    rest_start  = {1'b0, st.idx} + 4'd1;
    rest_nz     = first_nz(st.phase, rest_start, short_ticks, frame_ticks);
    wrap_nz     = first_nz(st.phase, 4'd0, short_ticks, frame_ticks);
    next_scan   = scan_patterns(4'(st.phase) + 4'd1, status_flags, repeat_count,
                                short_ticks, frame_ticks);
    reps_dec    = (st.reps != '0) ? st.reps - 1'b1 : '0;
    loaded_rest = rest_start < seg_cnt(st.phase);
    led_pre     = (loaded_rest || reps_dec != '0) ? 1'b0 : st.led;
    st_r1.ticks = (st.ticks != '0) ? st.ticks - 1'b1 : '0;

    if (st_r1.ticks == '0) begin
      unique case (st.phase) inside
        PH_GAP, PH_STEADY: begin
          start_pass = 1'b1;
        end
        PH_IDLE: begin
          st_r1.phase = PH_GAP;
          st_r1.ticks = sat_len(LEN_W'(gap_ticks));
          start_pass  = (gap_ticks == '0);
        end
        [PH_UPDATE:PH_POWER_FAST]: begin
          if (rest_nz.found) begin
            st_r1.idx   = rest_nz.idx;
            st_r1.led   = !rest_nz.idx[0];
            st_r1.ticks = sat_len(seg_len(st.phase, rest_nz.idx, short_ticks, frame_ticks));
          end else if (reps_dec != '0 && wrap_nz.found) begin
            st_r1.idx   = wrap_nz.idx;
            st_r1.reps  = reps_dec;
            st_r1.led   = !wrap_nz.idx[0];
            st_r1.ticks = sat_len(seg_len(st.phase, wrap_nz.idx, short_ticks, frame_ticks));
          end else begin
            st_r1.idx  = '0;
            st_r1.reps = '0;
            if (st.phase != PH_UPDATE && next_scan.hit) begin
              st_r1.phase = next_scan.phase;
              st_r1.idx   = next_scan.idx;
              st_r1.reps  = repeat_count;
              st_r1.led   = !next_scan.idx[0];
              st_r1.ticks = sat_len(seg_len(next_scan.phase, next_scan.idx,
                                            short_ticks, frame_ticks));
            end else begin
              st_r1.phase = PH_GAP;
              st_r1.ticks = sat_len(LEN_W'(gap_ticks));
              st_r1.led   = (st.phase != PH_UPDATE && next_scan.touched) ? 1'b0 : led_pre;
              start_pass  = (gap_ticks == '0);
            end
          end
        end
        default: begin
          st_r1 = st;
        end
      endcase
    end
  end

  // Round two: a new pass starts, at most once per tick.
  always_comb begin
    pass_scan = scan_patterns(4'(PH_UPDATE), status_flags, repeat_count,
                              short_ticks, frame_ticks);
    st_next   = st_r1;
    if (start_pass) begin
      if (status_flags == '0) begin
        st_next.led = 1'b0;
        if (short_ticks != '0) begin
          st_next.phase = PH_IDLE;
          st_next.ticks = sat_len(LEN_W'(short_ticks));
        end else begin
          st_next.phase = PH_GAP;
          st_next.ticks = sat_len(LEN_W'(gap_ticks));
        end
      end else if ((status_flags & PATTERN_MASK) == '0) begin
        st_next.ticks = sat_len(LEN_W'(gap_ticks));
        if (status_flags[FLAG_ON]) begin
          st_next.phase = PH_STEADY;
          st_next.led   = 1'b1;
        end else begin
          st_next.phase = PH_GAP;
        end
      end else if (pass_scan.hit) begin
        st_next.phase = pass_scan.phase;
        st_next.idx   = pass_scan.idx;
        st_next.reps  = repeat_count;
        st_next.led   = !pass_scan.idx[0];
        st_next.ticks = sat_len(seg_len(pass_scan.phase, pass_scan.idx,
                                        short_ticks, frame_ticks));
      end else begin
        st_next.phase = PH_GAP;
        st_next.ticks = sat_len(LEN_W'(gap_ticks));
        st_next.led   = pass_scan.touched ? 1'b0 : st_r1.led;
      end
    end
  end

  // Flag writes and the result of the beat.
  always_comb begin
    status_flags_next = status_flags;
    res_data          = {3'b000, 4'(st.phase), st.led};
    case (in_cmd)
      CMD_TICK: begin
        res_data = {3'b000, 4'(st_next.phase), st_next.led};
      end
      CMD_CLEAR: begin
        status_flags_next = '0;
      end
      CMD_WRITE: begin
        if (in_sel <= FLAG_LAST) status_flags_next[in_sel] = in_val;
      end
      default: begin
        status_flags_next = status_flags;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks  <= SHORT_RST;
      frame_ticks  <= FRAME_RST;
      gap_ticks    <= GAP_RST;
      repeat_count <= REPEAT_RST;
      status_flags <= '0;
      st.phase     <= PH_GAP;
      st.idx       <= '0;
      st.reps      <= '0;
      st.ticks     <= '0;
      st.led       <= 1'b0;
      m_tvalid     <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SHORT:  short_ticks  <= cfg_data[SHORT_W-1:0];
          REG_FRAME:  frame_ticks  <= cfg_data[FRAME_W-1:0];
          REG_GAP:    gap_ticks    <= cfg_data[GAP_W-1:0];
          REG_REPEAT: repeat_count <= cfg_data[REPEAT_W-1:0];
          default:    short_ticks  <= short_ticks;
        endcase
      end

      if (in_fire) begin
        status_flags <= status_flags_next;
        if (in_cmd == CMD_TICK) st <= st_next;
      end

      // A result goes to the output register when it is free, else to the skid entry.
      if (m_tvalid && !m_tready) begin
        if (in_fire) begin
          skid_valid <= 1'b1;
          skid_data  <= res_data;
        end
      end else if (skid_valid) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= in_fire;
        if (in_fire) m_tdata <= res_data;
      end
    end
  end

  // A waiting skid entry always sits behind a valid output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held without an output beat");

  // Inside a pattern the current segment always has time left.
  a_pattern_has_time: assert property (@(posedge clk) disable iff (rst)
    (st.phase >= PH_UPDATE && st.phase <= PH_POWER_FAST) |-> st.ticks != '0)
    else $error("pattern segment with no ticks left");

  // Steady passes keep the LED lit and the idle pass keeps it dark.
  a_steady_lit: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_STEADY |-> st.led) and (st.phase == PH_IDLE |-> !st.led))
    else $error("LED level does not match pass kind");

  // The sequencer and flags move only on an accepted beat.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> ($stable(st) && $stable(status_flags)))
    else $error("sequencer state changed without an input beat");

endmodule
